@@ hw/rtl/ptwm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ptwm_pkg;

    localparam int VA_W        = 48;
    localparam int PA_W        = 52;
    localparam int ENT_W       = 64;
    localparam int IDX_W       = 9;
    localparam int PAGE_SH     = 12;
    localparam int FRAME_W     = PA_W - PAGE_SH;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int STAT_W      = 3;
    localparam int STEP_W      = 3;

    localparam logic [2:0] TABLE_BITS = 3'b111;
    localparam int         PRESENT_BIT = 0;

    localparam logic CMD_MAP    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] ST_MAPPED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND   = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_SLOT = 3'd4;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_READ_DIR,
        OP_EVAL_DIR,
        OP_READ_LEAF,
        OP_EVAL_LEAF
    } t_op;

    // One microcode word: datapath operation, table level, and whether the
    // step leaves the program when the datapath reports that the walk ended.
    typedef struct packed {
        t_op        op;
        logic [1:0] lvl;
        logic       jmp_fin;
    } t_uword;

    typedef struct packed {
        logic       start;
        t_op        op;
        logic [1:0] lvl;
        logic       load_out;
    } t_ctl;

    typedef struct packed {
        logic finish;
        logic out_free;
    } t_dstat;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        case (step)
            3'd0:    ucode = '{op: OP_READ_DIR,  lvl: 2'd3, jmp_fin: 1'b0};
            3'd1:    ucode = '{op: OP_EVAL_DIR,  lvl: 2'd3, jmp_fin: 1'b1};
            3'd2:    ucode = '{op: OP_READ_DIR,  lvl: 2'd2, jmp_fin: 1'b0};
            3'd3:    ucode = '{op: OP_EVAL_DIR,  lvl: 2'd2, jmp_fin: 1'b1};
            3'd4:    ucode = '{op: OP_READ_DIR,  lvl: 2'd1, jmp_fin: 1'b0};
            3'd5:    ucode = '{op: OP_EVAL_DIR,  lvl: 2'd1, jmp_fin: 1'b1};
            3'd6:    ucode = '{op: OP_READ_LEAF, lvl: 2'd0, jmp_fin: 1'b0};
            3'd7:    ucode = '{op: OP_EVAL_LEAF, lvl: 2'd0, jmp_fin: 1'b1};
            default: ucode = '{op: OP_NOP,       lvl: 2'd0, jmp_fin: 1'b1};
        endcase
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ptwm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptwm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/ptwm_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptwm_seq
    import ptwm_pkg::*;
#(
    parameter int DEPTH = 32768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire t_dstat                   i_dstat,
    output t_ctl                          o_ctl,
    output logic                          o_clr_we,
    output logic      [$clog2(DEPTH)-1:0] o_clr_addr
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [AW-1:0]     r_clr,   n_clr;
    t_uword            uw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_clr   <= n_clr;
        end
    end

    always_comb begin
        uw             = ucode(r_step);
        n_state        = r_state;
        n_step         = r_step;
        n_clr          = r_clr;
        o_ready        = 1'b0;
        o_clr_we       = 1'b0;
        o_ctl.start    = 1'b0;
        o_ctl.op       = OP_NOP;
        o_ctl.lvl      = 2'd0;
        o_ctl.load_out = 1'b0;
        case (r_state)
            S_CLEAR: begin
                // Zero the whole store, one entry per cycle, after reset.
                o_clr_we = 1'b1;
                n_clr    = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.start = 1'b1;
                    n_step      = '0;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                o_ctl.op  = uw.op;
                o_ctl.lvl = uw.lvl;
                if (uw.jmp_fin && i_dstat.finish) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                if (i_dstat.out_free) begin
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_clr_addr = r_clr;

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_RUN && r_step == '0))
        else $error("accepted beat did not start the program at step zero");

    a_leaf_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && uw.op == OP_EVAL_LEAF) |=> (r_state == S_DONE))
        else $error("leaf evaluation did not end the walk");

    a_no_run_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (uw.op != OP_NOP))
        else $error("program ran past its last step");

endmodule

`default_nettype wire

@@ hw/rtl/ptwm_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptwm_dp
    import ptwm_pkg::*;
#(
    parameter int TABLE_SLOTS = 64,
    parameter int SLOT_W      = 6,
    parameter int NF_W        = 7
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_ctl                      i_ctl,
    output t_dstat                         o_dstat,
    input  wire logic                      i_cfg_we,
    input  wire logic [PA_W-1:0]           i_cfg_wdata,
    input  wire logic                      i_command,
    input  wire logic [VA_W-1:0]           i_virtual_address,
    input  wire logic [PA_W-1:0]           i_phys_address,
    input  wire logic [ENT_W-1:0]          i_flags,
    input  wire logic [ENT_W-1:0]          i_rdata,
    output logic      [SLOT_W+IDX_W-1:0]   o_addr,
    output logic                           o_we,
    output logic      [ENT_W-1:0]          o_wdata,
    input  wire logic                      i_ready,
    output logic                           o_valid,
    output logic      [STAT_W-1:0]         o_status,
    output logic      [ENT_W-1:0]          o_leaf_entry
);

    localparam logic [FRAME_W-1:0] SLOTS_F = FRAME_W'(TABLE_SLOTS);
    localparam logic [NF_W-1:0]    SLOTS_N = NF_W'(TABLE_SLOTS);

    // Control state
    logic [FRAME_W-1:0] r_base,      n_base;
    logic [NF_W-1:0]    r_next_free, n_next_free;
    logic               r_ovalid,    n_ovalid;

    // Payload
    logic               r_cmd;
    logic [VA_W-1:0]    r_va;
    logic [PA_W-1:0]    r_phys;
    logic [ENT_W-1:0]   r_flags;
    logic [SLOT_W-1:0]  r_slot,      n_slot;
    logic [STAT_W-1:0]  r_res_status, n_res_status;
    logic [ENT_W-1:0]   r_res_leaf,   n_res_leaf;
    logic [STAT_W-1:0]  r_ostatus;
    logic [ENT_W-1:0]   r_oleaf;

    logic [IDX_W-1:0]   idx;
    logic               present;
    logic [FRAME_W-1:0] diff;
    logic               stale;
    logic               full;
    logic [FRAME_W-1:0] new_frame;
    logic [ENT_W-1:0]   new_dir;
    logic [ENT_W-1:0]   new_leaf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_next_free <= NF_W'(1);
            r_ovalid    <= 1'b0;
        end else begin
            r_base      <= n_base;
            r_next_free <= n_next_free;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_cmd   <= i_command;
            r_va    <= i_virtual_address;
            r_phys  <= i_phys_address;
            r_flags <= i_flags;
        end
        if (i_ctl.load_out) begin
            r_ostatus <= r_res_status;
            r_oleaf   <= r_res_leaf;
        end
        r_slot       <= n_slot;
        r_res_status <= n_res_status;
        r_res_leaf   <= n_res_leaf;
    end

    always_comb begin
        case (i_ctl.lvl)
            2'd3:    idx = r_va[47:39];
            2'd2:    idx = r_va[38:30];
            2'd1:    idx = r_va[29:21];
            default: idx = r_va[20:12];
        endcase
    end

    assign o_addr    = {r_slot, idx};
    assign present   = i_rdata[PRESENT_BIT];
    // Slot number a directory entry points at, relative to the table area.
    assign diff      = i_rdata[PA_W-1:PAGE_SH] - r_base;
    assign stale     = (diff >= SLOTS_F);
    assign full      = (r_next_free >= SLOTS_N);
    assign new_frame = r_base + FRAME_W'(r_next_free);
    assign new_dir   = {{(ENT_W - PA_W){1'b0}}, new_frame, {(PAGE_SH - 3){1'b0}}, TABLE_BITS};
    assign new_leaf  = {{(ENT_W - PA_W){1'b0}}, r_phys} | r_flags;

    always_comb begin
        n_base           = i_cfg_we ? i_cfg_wdata[PA_W-1:PAGE_SH] : r_base;
        n_next_free      = r_next_free;
        n_slot           = r_slot;
        n_res_status     = r_res_status;
        n_res_leaf       = r_res_leaf;
        o_dstat.finish   = 1'b0;
        o_dstat.out_free = !r_ovalid || i_ready;
        o_we             = 1'b0;
        o_wdata          = new_dir;

        if (i_ctl.start) begin
            n_slot = '0;
        end

        case (i_ctl.op)
            OP_EVAL_DIR: begin
                if (present) begin
                    if (stale) begin
                        o_dstat.finish = 1'b1;
                        n_res_status   = ST_MISSING;
                        n_res_leaf     = '0;
                    end else begin
                        n_slot = diff[SLOT_W-1:0];
                    end
                end else if (r_cmd == CMD_LOOKUP) begin
                    o_dstat.finish = 1'b1;
                    n_res_status   = ST_MISSING;
                    n_res_leaf     = '0;
                end else if (full) begin
                    o_dstat.finish = 1'b1;
                    n_res_status   = ST_NO_SLOT;
                    n_res_leaf     = '0;
                end else begin
                    // New table: the slot is still all zero from the clearing pass.
                    o_we        = 1'b1;
                    n_slot      = r_next_free[SLOT_W-1:0];
                    n_next_free = r_next_free + 1'b1;
                end
            end
            OP_EVAL_LEAF: begin
                o_dstat.finish = 1'b1;
                if (r_cmd == CMD_LOOKUP) begin
                    n_res_status = ST_FOUND;
                    n_res_leaf   = i_rdata;
                end else if (present) begin
                    n_res_status = ST_PRESENT;
                    n_res_leaf   = i_rdata;
                end else begin
                    o_we         = 1'b1;
                    o_wdata      = new_leaf;
                    n_res_status = ST_MAPPED;
                    n_res_leaf   = new_leaf;
                end
            end
            default: begin
            end
        endcase

        if (i_ctl.load_out) begin
            n_ovalid = 1'b1;
        end else if (i_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_leaf_entry = r_oleaf;

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free >= NF_W'(1)) && (r_next_free <= SLOTS_N))
        else $error("free slot counter out of range");

    a_lookup_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_cmd == CMD_MAP))
        else $error("lookup wrote the table store");

    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load_out |=> (r_ovalid && r_ostatus == $past(r_res_status)))
        else $error("result not moved into the output register");

endmodule

`default_nettype wire

@@ hw/rtl/page_table_walk_map_core.sv @@
// Walk: one item at a time; a new input beat is taken only in idle. Each level is a registered
// table-store read followed by its evaluation; a walk that ends at an upper level skips the
// steps of the remaining levels. The result then waits until the output register is free, is
// loaded into it, and the core returns to idle. Reset: synchronous, active low; afterwards the
// store is zeroed before the first input beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module page_table_walk_map_core
    import ptwm_pkg::*;
#(
    parameter int TABLE_SLOTS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [PA_W-1:0]    i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_command,
    input  wire logic [VA_W-1:0]    i_virtual_address,
    input  wire logic [PA_W-1:0]    i_phys_address,
    input  wire logic [ENT_W-1:0]   i_flags,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic      [STAT_W-1:0]  o_status,
    output logic      [ENT_W-1:0]   o_leaf_entry
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int NF_W   = $clog2(TABLE_SLOTS + 1);
    localparam int AW     = SLOT_W + IDX_W;
    localparam int DEPTH  = TABLE_SLOTS * ENTRIES_PER_TABLE;

    t_ctl              ctl;
    t_dstat            dstat;
    logic              clr_we;
    logic [AW-1:0]     clr_addr;
    logic [AW-1:0]     dp_addr;
    logic              dp_we;
    logic [ENT_W-1:0]  dp_wdata;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;

    ptwm_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_dstat    (dstat),
        .o_ctl      (ctl),
        .o_clr_we   (clr_we),
        .o_clr_addr (clr_addr)
    );

    ptwm_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W),
        .NF_W        (NF_W)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_dstat           (dstat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_command         (i_command),
        .i_virtual_address (i_virtual_address),
        .i_phys_address    (i_phys_address),
        .i_flags           (i_flags),
        .i_rdata           (ram_rdata),
        .o_addr            (dp_addr),
        .o_we              (dp_we),
        .o_wdata           (dp_wdata),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_leaf_entry      (o_leaf_entry)
    );

    assign ram_we    = clr_we | dp_we;
    assign ram_waddr = clr_we ? clr_addr : dp_addr;
    assign ram_wdata = clr_we ? '0 : dp_wdata;

    ptwm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (dp_addr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
